// File: src/region_color_coverage_assert.svh
// ----------------------------------------------------------------------------
// Region color coverage assertion macros
// Shared assertion forms used by the checker of the coverage block.
// ----------------------------------------------------------------------------
`ifndef REGION_COLOR_COVERAGE_ASSERT_SVH
`define REGION_COLOR_COVERAGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RCC_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("coverage block assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RCC_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("coverage block assertion failed");

// Next-cycle implication that also holds across reset.
`define RCC_ASSERT_RST(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("coverage block reset assertion failed");

`endif

// File: src/rcc_pkg.sv
// ----------------------------------------------------------------------------
// Region color coverage package
// Field widths, command and register codes, and the queued operation type.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // Field widths of the stream items.
    localparam int ROW_W    = 9;
    localparam int COL_W    = 10;
    localparam int END_W    = 11;
    localparam int HSV_W    = 8;
    localparam int CNT_W    = 20;
    localparam int PCT_W    = 7;
    localparam int RID_W    = 2;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W  = 56;

    // One span table entry holds the end column above the start column.
    localparam int SPAN_W = COL_W + END_W;

    // At most three regions produce results.
    localparam int MAX_REGIONS = 3;

    // Counter ceiling and the full-coverage percentage.
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 2'd3;

    // Operation kinds after classification.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PIXEL = 2'd2
    } op_kind_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        op_kind_t               kind;
        logic [RID_W-1:0]       region;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [END_W-1:0]       span_end;
        logic                   frame_end;
    } op_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: src/rcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rcc_queue.sv
// ----------------------------------------------------------------------------
// Region color coverage operation queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module rcc_queue
    import rcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  op_t     push_op,
    input  logic    pop,
    output op_t     head_op,
    output q_stat_t q_stat
);

    op_t              entries_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op      = entries_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// File: src/rcc_front.sv
// ----------------------------------------------------------------------------
// Region color coverage front end
// Holds the color window, accepts items and classifies them for the queue.
// ----------------------------------------------------------------------------
module rcc_front
    import rcc_pkg::*;
#(
    parameter int ROWS    = 512,
    parameter int COLS    = 1024,
    parameter int REGIONS = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input item stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: region_sel(2), row(9), column(10), span_end(11),
    // hue(8), saturation(8), brightness(8).
    input  logic [TDATA_W-1:0]   s_tdata,
    // s_tuser: command(1).
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    // Configuration writes.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Queue side.
    input  q_stat_t              q_stat,
    input  logic                 clear_busy,
    output logic                 push,
    output op_t                  push_op
);

    localparam int NREG = (REGIONS < MAX_REGIONS) ? REGIONS : MAX_REGIONS;
    localparam logic [3:0]  NREG_V = 4'(NREG);
    localparam logic [12:0] ROWS_V = 13'(ROWS);
    localparam logic [12:0] COLS_V = 13'(COLS);

    logic [CFG_W-1:0] hue_low_reg;
    logic [CFG_W-1:0] hue_high_reg;
    logic [CFG_W-1:0] sat_low_reg;
    logic [CFG_W-1:0] val_low_reg;

    logic [RID_W-1:0] region_sel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [END_W-1:0] span_end;
    logic [HSV_W-1:0] hue;
    logic [HSV_W-1:0] saturation;
    logic [HSV_W-1:0] brightness;
    logic             row_ok;
    logic             color_ok;
    logic             load_ok;
    logic             pixel_ok;
    logic [END_W-1:0] end_clamped;
    op_kind_t         kind;

    // Color window registers, written one at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= '0;
            hue_high_reg <= '1;
            sat_low_reg  <= '0;
            val_low_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HUE_LOW:  hue_low_reg  <= cfg_wdata;
                CFG_HUE_HIGH: hue_high_reg <= cfg_wdata;
                CFG_SAT_LOW:  sat_low_reg  <= cfg_wdata;
                CFG_VAL_LOW:  val_low_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Field unpacking.
    assign region_sel = s_tdata[1:0];
    assign row        = s_tdata[10:2];
    assign column     = s_tdata[20:11];
    assign span_end   = s_tdata[31:21];
    assign hue        = s_tdata[39:32];
    assign saturation = s_tdata[47:40];
    assign brightness = s_tdata[55:48];

    // Classification: rows outside the image, unknown load regions and unmatched
    // pixels are dropped, and a span end past the image is clamped to the image width.
    always_comb begin
        row_ok   = (13'(row) < ROWS_V);
        color_ok = (hue > hue_low_reg) && (hue < hue_high_reg)
                && (saturation > sat_low_reg) && (brightness > val_low_reg);
        load_ok  = (s_tuser == CMD_LOAD) && row_ok && (4'(region_sel) < NREG_V);
        pixel_ok = (s_tuser == CMD_PIXEL) && row_ok && color_ok;
        end_clamped = (13'(span_end) > COLS_V) ? END_W'(COLS) : span_end;
        if (load_ok) begin
            kind = OP_LOAD;
        end else if (pixel_ok) begin
            kind = OP_PIXEL;
        end else begin
            kind = OP_NONE;
        end
    end

    // Items that change nothing and end no frame are taken and dropped here.
    assign s_tready = !q_stat.full && !clear_busy;
    assign push     = s_tvalid && s_tready && ((kind != OP_NONE) || s_tlast);

    assign push_op.kind      = kind;
    assign push_op.region    = region_sel;
    assign push_op.row       = row;
    assign push_op.col       = column;
    assign push_op.span_end  = end_clamped;
    assign push_op.frame_end = s_tlast;

endmodule

// File: src/rcc_back.sv
// ----------------------------------------------------------------------------
// Region color coverage back end
// Span tables, area sums, match counters, percentage division and results.
// ----------------------------------------------------------------------------
module rcc_back
    import rcc_pkg::*;
#(
    parameter int ROWS    = 512,
    parameter int COLS    = 1024,
    parameter int REGIONS = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Queue side.
    input  q_stat_t            q_stat,
    input  op_t                head_op,
    output logic               pop,
    output logic               clear_busy,
    // Result stream.
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata from bit 0: region_id(2), percent(7), match_count(20),
    // region_area(20), empty_region(1), zero fill(6).
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam int NREG   = (REGIONS < MAX_REGIONS) ? REGIONS : MAX_REGIONS;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int AREA_W = $clog2(ROWS * COLS + 1);
    localparam int DIV_W  = ((AREA_W > CNT_W) ? AREA_W : CNT_W) + PCT_W;
    localparam int K_W    = (NREG > 1) ? $clog2(NREG) : 1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic [ROW_AW-1:0] clr_cnt_next;
    op_t               op_reg;
    op_t               op_next;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [2:0]        step_reg;
    logic [2:0]        step_next;
    logic [PCT_W-1:0]  quo_reg;
    logic [PCT_W-1:0]  quo_next;
    logic [AREA_W-1:0] area_cur_reg;
    logic [AREA_W-1:0] area_cur_next;
    logic [CNT_W-1:0]  cnt_cur_reg;
    logic [CNT_W-1:0]  cnt_cur_next;
    logic              sat_reg;
    logic              sat_next;
    logic              empty_reg;
    logic              empty_next;
    logic [AREA_W-1:0] area_reg [NREG];
    logic [AREA_W-1:0] area_next [NREG];
    logic [CNT_W-1:0]  cnt_reg [NREG];
    logic [CNT_W-1:0]  cnt_next [NREG];

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [RID_W-1:0]  out_region_reg;
    logic [RID_W-1:0]  out_region_next;
    logic [PCT_W-1:0]  out_pct_reg;
    logic [PCT_W-1:0]  out_pct_next;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [CNT_W-1:0]  out_cnt_next;
    logic [CNT_W-1:0]  out_area_reg;
    logic [CNT_W-1:0]  out_area_next;
    logic              out_empty_reg;
    logic              out_empty_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [SPAN_W-1:0] span_rd [NREG];
    logic [END_W-1:0]  old_w [NREG];
    logic              hit [NREG];
    logic [END_W-1:0]  new_w;
    logic              clearing;
    logic [ROW_AW-1:0] wr_addr;
    logic [SPAN_W-1:0] wr_data;
    logic [ROW_AW-1:0] rd_addr;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  product;
    logic              slot_free;
    logic              k_last;

    assign clearing = (state_reg == S_CLEAR);
    assign wr_addr  = clearing ? clr_cnt_reg : ROW_AW'(op_reg.row);
    assign wr_data  = clearing ? '0 : {op_reg.span_end, op_reg.col};
    assign rd_addr  = ROW_AW'(head_op.row);

    // Width of the span being loaded.
    assign new_w = (op_reg.span_end > {1'b0, op_reg.col})
                 ? op_reg.span_end - {1'b0, op_reg.col} : '0;

    // One span table per region; all are read at the row of the queue head.
    for (genvar r = 0; r < NREG; r++) begin : g_region
        logic              wr_en;
        logic [COL_W-1:0]  start_col;
        logic [END_W-1:0]  end_col;

        assign wr_en = clearing || ((state_reg == S_EXEC) && (op_reg.kind == OP_LOAD)
                                    && (op_reg.region == RID_W'(r)));

        rcc_ram #(
            .WIDTH (SPAN_W),
            .DEPTH (ROWS)
        ) u_span_ram (
            .clk     (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr),
            .rd_data (span_rd[r])
        );

        // Old span width and column hit test; empty spans match nothing.
        assign start_col = span_rd[r][COL_W-1:0];
        assign end_col   = span_rd[r][SPAN_W-1:COL_W];
        assign old_w[r]  = (end_col > {1'b0, start_col}) ? end_col - {1'b0, start_col} : '0;
        assign hit[r]    = (op_reg.col >= start_col) && ({1'b0, op_reg.col} < end_col);
    end

    assign slot_free = !m_tvalid_reg || m_tready;
    assign k_last    = (k_reg == K_W'(NREG - 1));
    assign shifted   = DIV_W'(area_cur_reg) << step_reg;
    assign product   = DIV_W'(cnt_reg[k_reg]) * DIV_W'(PCT_FULL);

    // Sequencer: clearing pass, item execution, then per-region reporting.
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        k_next          = k_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        quo_next        = quo_reg;
        area_cur_next   = area_cur_reg;
        cnt_cur_next    = cnt_cur_reg;
        sat_next        = sat_reg;
        empty_next      = empty_reg;
        area_next       = area_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_region_next = out_region_reg;
        out_pct_next    = out_pct_reg;
        out_cnt_next    = out_cnt_reg;
        out_area_next   = out_area_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    op_next    = head_op;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // Span data for this row is now out of the tables.
                for (int r = 0; r < NREG; r++) begin
                    if ((op_reg.kind == OP_LOAD) && (op_reg.region == RID_W'(r))) begin
                        area_next[r] = area_reg[r] - AREA_W'(old_w[r]) + AREA_W'(new_w);
                    end
                    if ((op_reg.kind == OP_PIXEL) && hit[r] && (cnt_reg[r] != CNT_MAX)) begin
                        cnt_next[r] = cnt_reg[r] + 1'b1;
                    end
                end
                if (op_reg.frame_end) begin
                    k_next     = '0;
                    state_next = S_MUL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_MUL: begin
                // Scale the count; a count at or above the area means full coverage.
                rem_next      = product;
                area_cur_next = area_reg[k_reg];
                cnt_cur_next  = cnt_reg[k_reg];
                sat_next      = (DIV_W'(cnt_reg[k_reg]) >= DIV_W'(area_reg[k_reg]));
                empty_next    = (area_reg[k_reg] == '0);
                step_next     = 3'(PCT_W - 1);
                quo_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_reg >= shifted) begin
                    rem_next = rem_reg - shifted;
                    quo_next = {quo_reg[PCT_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[PCT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next   = 1'b1;
                    out_region_next = RID_W'(k_reg);
                    out_cnt_next    = cnt_cur_reg;
                    out_empty_next  = empty_reg;
                    out_last_next   = k_last;
                    out_area_next   = (DIV_W'(area_cur_reg) > DIV_W'(CNT_MAX))
                                    ? CNT_MAX : CNT_W'(area_cur_reg);
                    if (empty_reg) begin
                        out_pct_next = '0;
                    end else if (sat_reg) begin
                        out_pct_next = PCT_FULL;
                    end else begin
                        out_pct_next = quo_reg;
                    end
                    if (k_last) begin
                        for (int r = 0; r < NREG; r++) begin
                            cnt_next[r] = '0;
                        end
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and running sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            for (int r = 0; r < NREG; r++) begin
                area_reg[r] <= '0;
                cnt_reg[r]  <= '0;
            end
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
            area_reg     <= area_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        quo_reg        <= quo_next;
        area_cur_reg   <= area_cur_next;
        cnt_cur_reg    <= cnt_cur_next;
        sat_reg        <= sat_next;
        empty_reg      <= empty_next;
        out_region_reg <= out_region_next;
        out_pct_reg    <= out_pct_next;
        out_cnt_reg    <= out_cnt_next;
        out_area_reg   <= out_area_next;
        out_empty_reg  <= out_empty_next;
        out_last_reg   <= out_last_next;
    end

    assign clear_busy = clearing;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tlast    = out_last_reg;
    assign m_tdata    = {6'd0, out_empty_reg, out_area_reg, out_cnt_reg,
                         out_pct_reg, out_region_reg};

endmodule

// File: src/region_color_coverage.sv
// ----------------------------------------------------------------------------
// Region color coverage
// Per-region share of pixels whose HSV color lies inside a window.
// ----------------------------------------------------------------------------
// Load items write one row span per region; pixel items are counted against
// the spans of their row, and the frame-end item produces one result per
// region (up to three) with floor(count*100/area), capped at 100. After reset
// the span tables are cleared row by row, and no item is accepted until
// that pass is done. The front accepts one item per cycle into a four-entry
// queue while the queue is not full; items that neither match nor end a frame
// are dropped at the front. The back handles each load or matching pixel as a
// span table read, then an update, and takes no new item until it is done.
// A frame end adds, per region, a scaling multiply, seven division steps and a
// result write, plus any wait on m_tready.
module region_color_coverage
    import rcc_pkg::*;
#(
    parameter int ROWS    = 512,
    parameter int COLS    = 1024,
    parameter int REGIONS = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input item stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: region_sel(2), row(9), column(10), span_end(11),
    // hue(8), saturation(8), brightness(8).
    input  logic [TDATA_W-1:0]   s_tdata,
    // s_tuser: command(1).
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: region_id(2), percent(7), match_count(20),
    // region_area(20), empty_region(1), zero fill(6).
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,
    // Configuration writes.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    q_stat_t q_stat;
    logic    push;
    op_t     push_op;
    logic    pop;
    op_t     head_op;
    logic    clear_busy;

    // Accept and classify.
    rcc_front #(
        .ROWS    (ROWS),
        .COLS    (COLS),
        .REGIONS (REGIONS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_stat     (q_stat),
        .clear_busy (clear_busy),
        .push       (push),
        .push_op    (push_op)
    );

    // Decoupling queue.
    rcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    // Execute and report.
    rcc_back #(
        .ROWS    (ROWS),
        .COLS    (COLS),
        .REGIONS (REGIONS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head_op    (head_op),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: src/rcc_checker.sv
// ----------------------------------------------------------------------------
// Region color coverage checker
// Port-level assertions on the result stream and the reset behavior.
// ----------------------------------------------------------------------------
`include "region_color_coverage_assert.svh"

module rcc_checker
    import rcc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // A stalled result item keeps its contents.
    `RCC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // The empty flag marks exactly a zero area, and then the percentage is zero.
    `RCC_ASSERT_IMP(a_empty_flag, aclk, aresetn, m_tvalid, (m_tdata[49] == (m_tdata[48:29] == 20'd0)) && (!m_tdata[49] || (m_tdata[8:2] == 7'd0)))

    // Percentage never exceeds full coverage.
    `RCC_ASSERT_IMP(a_pct_range, aclk, aresetn, m_tvalid, m_tdata[8:2] <= 7'd100)

    // A count at or above a nonzero area reports full coverage.
    `RCC_ASSERT_IMP(a_pct_sat, aclk, aresetn, m_tvalid && !m_tdata[49] && (m_tdata[28:9] >= m_tdata[48:29]), m_tdata[8:2] == 7'd100)

    // The table clearing pass holds off input right after reset.
    `RCC_ASSERT_RST(a_clear_after_reset, aclk, !aresetn, !s_tready)

endmodule

bind region_color_coverage rcc_checker u_rcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
